// ===== design/assert_macros.svh =====
// Assertion macros shared by the clipper RTL.
// Needs nothing else; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("npclip assertion failed");
`define NPC_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("npclip forbidden condition");
`else
`define NPC_ASSERT(lbl, clk, rstn, prop)
`define NPC_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ===== design/npclip_pkg.sv =====
// Types and constants of the near-plane triangle clipper.
// Used by near_plane_triangle_clip; depends on nothing.
package npclip_pkg;

  localparam int COORD_W   = 32;
  localparam int NEAR_W    = COORD_W - 1;
  localparam int PROD_W    = COORD_W + NEAR_W;
  localparam int DIV_STEPS = COORD_W;
  localparam int LANES     = 4;
  localparam logic [NEAR_W-1:0] NEAR_RESET = NEAR_W'(6554);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    vtx_t a;
    vtx_t b;
    vtx_t c;
  } tri_t;

  typedef struct packed {
    logic [1:0] ni;
    vtx_t       i0;
    vtx_t       i1;
    vtx_t       i2;
  } meta_t;

  typedef struct packed {
    logic               neg;
    logic [COORD_W-1:0] mag;
    logic [NEAR_W-1:0]  a;
    logic [COORD_W-1:0] b;
  } lane_in_t;

  typedef struct packed {
    logic               neg;
    logic [PROD_W-1:0]  prod;
    logic [COORD_W-1:0] b;
  } lane_prod_t;

  typedef struct packed {
    logic               neg;
    logic [COORD_W-1:0] b;
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] lq;
  } lane_div_t;

endpackage

// ===== design/near_plane_triangle_clip.sv =====
// Near-plane triangle clipper: one triangle in, zero to two triangles out.
// Depends on npclip_pkg and assert_macros.svh.
//
// One triangle can enter every cycle while each yields at most one result and the output
// is not stalled; a triangle that yields two results holds the single output register for
// both of them, and the pipeline hands over no further triangle while the second one waits.
// Each cut coordinate is an exact rounded quotient from a 32-step restoring divider, one
// quotient bit per pipeline stage. A stall on the output holds the whole pipeline once its
// last stage holds a triangle.
`include "assert_macros.svh"

module near_plane_triangle_clip (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [npclip_pkg::NEAR_W-1:0]      cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [npclip_pkg::COORD_W-1:0] v0_x_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v0_y_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v0_z_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v1_x_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v1_y_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v1_z_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v2_x_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v2_y_i,
  input  logic signed [npclip_pkg::COORD_W-1:0] v2_z_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [npclip_pkg::COORD_W-1:0] out0_x_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out0_y_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out0_z_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out1_x_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out1_y_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out1_z_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out2_x_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out2_y_o,
  output logic signed [npclip_pkg::COORD_W-1:0] out2_z_o,
  output logic                               last_of_run_o
);

  localparam int CW   = npclip_pkg::COORD_W;
  localparam int NW   = npclip_pkg::NEAR_W;
  localparam int Last = npclip_pkg::DIV_STEPS + 4;
  localparam int NL   = npclip_pkg::LANES;

  logic [NW-1:0] near_q;
  logic          adv;
  logic          valid_q [0:Last];

  npclip_pkg::vtx_t       v_q [0:2];
  npclip_pkg::meta_t      meta_q [1:Last];
  npclip_pkg::meta_t      meta_d;
  npclip_pkg::lane_in_t   lin_d [0:NL-1];
  npclip_pkg::lane_in_t   lin_q [0:NL-1];
  npclip_pkg::lane_prod_t lprod_q [0:NL-1];
  npclip_pkg::lane_div_t  ldiv_q [0:npclip_pkg::DIV_STEPS][0:NL-1];
  npclip_pkg::vtx_t       c1_d, c2_d, c1_q, c2_q;

  npclip_pkg::tri_t out_tri_q, pend_tri_q, first_tri, second_tri;
  logic             out_valid_q, pend_q, out_last_q;
  logic             can_take, take;

  function automatic npclip_pkg::lane_div_t div_step(npclip_pkg::lane_div_t s);
    npclip_pkg::lane_div_t r;
    logic [CW:0] t;
    logic [CW:0] bx;
    logic        ge;
    t  = {s.rem, s.lq[CW-1]};
    bx = {1'b0, s.b};
    ge = (t >= bx);
    r     = s;
    r.rem = ge ? CW'(t - bx) : t[CW-1:0];
    r.lq  = {s.lq[CW-2:0], ge};
    return r;
  endfunction

  function automatic logic signed [CW-1:0] cut_coord(logic signed [CW-1:0] p,
                                                   logic neg, logic [CW-1:0] off);
    logic signed [CW+1:0] sum;
    logic signed [CW+1:0] offx;
    offx = $signed({2'b00, off});
    sum  = $signed({{2{p[CW-1]}}, p}) + (neg ? -offx : offx);
    if (sum > $signed({3'b000, {(CW-1){1'b1}}})) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (sum < -$signed({3'b001, {(CW-1){1'b0}}})) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return sum[CW-1:0];
    end
  endfunction

  function automatic npclip_pkg::lane_in_t mk_lane(logic signed [CW-1:0] pc,
                                                   logic signed [CW-1:0] qc,
                                                   logic signed [CW-1:0] pz,
                                                   logic signed [CW-1:0] qz,
                                                   logic [NW-1:0] nz);
    npclip_pkg::lane_in_t r;
    logic signed [CW:0] d;
    logic signed [CW:0] a;
    d     = $signed({qc[CW-1], qc}) - $signed({pc[CW-1], pc});
    a     = $signed({pz[CW-1], pz}) - $signed({2'b00, nz});
    r.neg = d[CW];
    r.mag = d[CW] ? CW'(-d) : d[CW-1:0];
    r.a   = a[NW-1:0];
    r.b   = CW'(pz - qz);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= npclip_pkg::NEAR_RESET;
    end else if (cfg_we_i) begin
      near_q <= cfg_wdata_i;
    end
  end

  assign can_take   = !out_valid_q || (out_ready_i && !pend_q);
  assign adv        = !valid_q[Last] || can_take;
  assign take       = valid_q[Last] && can_take;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Last; s++) begin
        valid_q[s] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= in_valid_i;
      for (int s = 1; s <= Last; s++) begin
        valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_comb begin
    logic [2:0] ins;
    npclip_pkg::vtx_t o0, o1;
    for (int i = 0; i < 3; i++) begin
      ins[i] = $signed({v_q[i].z[CW-1], v_q[i].z}) >= $signed({2'b00, near_q});
    end
    meta_d.ni = 2'd0;
    meta_d.i0 = v_q[0];
    meta_d.i1 = v_q[1];
    meta_d.i2 = v_q[2];
    o0 = v_q[1];
    o1 = v_q[2];
    case (ins)
      3'b111: meta_d.ni = 2'd3;
      3'b001: begin
        meta_d.ni = 2'd1;
      end
      3'b010: begin
        meta_d.ni = 2'd1; meta_d.i0 = v_q[1]; o0 = v_q[0];
      end
      3'b100: begin
        meta_d.ni = 2'd1; meta_d.i0 = v_q[2]; o0 = v_q[0]; o1 = v_q[1];
      end
      3'b011: begin
        meta_d.ni = 2'd2; o0 = v_q[2];
      end
      3'b101: begin
        meta_d.ni = 2'd2; meta_d.i1 = v_q[2]; o0 = v_q[1];
      end
      3'b110: begin
        meta_d.ni = 2'd2; meta_d.i0 = v_q[1]; meta_d.i1 = v_q[2]; o0 = v_q[0];
      end
      default: meta_d.ni = 2'd0;
    endcase
    lin_d[0] = mk_lane(meta_d.i0.x, o0.x, meta_d.i0.z, o0.z, near_q);
    lin_d[1] = mk_lane(meta_d.i0.y, o0.y, meta_d.i0.z, o0.z, near_q);
    if (meta_d.ni == 2'd2) begin
      lin_d[2] = mk_lane(meta_d.i1.x, o0.x, meta_d.i1.z, o0.z, near_q);
      lin_d[3] = mk_lane(meta_d.i1.y, o0.y, meta_d.i1.z, o0.z, near_q);
    end else begin
      lin_d[2] = mk_lane(meta_d.i0.x, o1.x, meta_d.i0.z, o1.z, near_q);
      lin_d[3] = mk_lane(meta_d.i0.y, o1.y, meta_d.i0.z, o1.z, near_q);
    end
  end

  always_comb begin
    npclip_pkg::vtx_t p2;
    p2 = (meta_q[Last-1].ni == 2'd2) ? meta_q[Last-1].i1 : meta_q[Last-1].i0;
    c1_d.x = cut_coord(meta_q[Last-1].i0.x, ldiv_q[npclip_pkg::DIV_STEPS][0].neg,
                       ldiv_q[npclip_pkg::DIV_STEPS][0].lq);
    c1_d.y = cut_coord(meta_q[Last-1].i0.y, ldiv_q[npclip_pkg::DIV_STEPS][1].neg,
                       ldiv_q[npclip_pkg::DIV_STEPS][1].lq);
    c1_d.z = $signed({1'b0, near_q});
    c2_d.x = cut_coord(p2.x, ldiv_q[npclip_pkg::DIV_STEPS][2].neg,
                       ldiv_q[npclip_pkg::DIV_STEPS][2].lq);
    c2_d.y = cut_coord(p2.y, ldiv_q[npclip_pkg::DIV_STEPS][3].neg,
                       ldiv_q[npclip_pkg::DIV_STEPS][3].lq);
    c2_d.z = $signed({1'b0, near_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      v_q[0] <= '{x: v0_x_i, y: v0_y_i, z: v0_z_i};
      v_q[1] <= '{x: v1_x_i, y: v1_y_i, z: v1_z_i};
      v_q[2] <= '{x: v2_x_i, y: v2_y_i, z: v2_z_i};
      meta_q[1] <= meta_d;
      for (int s = 2; s <= Last; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
      for (int l = 0; l < NL; l++) begin
        logic [2*CW-1:0] n;
        lin_q[l]      <= lin_d[l];
        lprod_q[l].neg  <= lin_q[l].neg;
        lprod_q[l].b    <= lin_q[l].b;
        lprod_q[l].prod <= lin_q[l].mag * lin_q[l].a;
        n = {1'b0, lprod_q[l].prod} + (2*CW)'(lprod_q[l].b >> 1);
        ldiv_q[0][l].neg <= lprod_q[l].neg;
        ldiv_q[0][l].b   <= lprod_q[l].b;
        ldiv_q[0][l].rem <= n[2*CW-1:CW];
        ldiv_q[0][l].lq  <= n[CW-1:0];
        for (int k = 0; k < npclip_pkg::DIV_STEPS; k++) begin
          ldiv_q[k+1][l] <= div_step(ldiv_q[k][l]);
        end
      end
      c1_q <= c1_d;
      c2_q <= c2_d;
    end
  end

  always_comb begin
    first_tri  = '{a: meta_q[Last].i0, b: meta_q[Last].i1, c: meta_q[Last].i2};
    second_tri = '{a: meta_q[Last].i0, b: meta_q[Last].i1, c: c2_q};
    case (meta_q[Last].ni)
      2'd1:    first_tri = '{a: meta_q[Last].i0, b: c1_q, c: c2_q};
      2'd2:    first_tri = '{a: meta_q[Last].i0, b: c2_q, c: c1_q};
      default: first_tri = '{a: meta_q[Last].i0, b: meta_q[Last].i1, c: meta_q[Last].i2};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (take) begin
      out_valid_q <= (meta_q[Last].ni != 2'd0);
      pend_q      <= (meta_q[Last].ni == 2'd2);
    end else if (out_valid_q && out_ready_i) begin
      if (pend_q) begin
        pend_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_tri_q  <= first_tri;
      out_last_q <= (meta_q[Last].ni != 2'd2);
      pend_tri_q <= second_tri;
    end else if (out_valid_q && out_ready_i && pend_q) begin
      out_tri_q  <= pend_tri_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out0_x_o      = out_tri_q.a.x;
  assign out0_y_o      = out_tri_q.a.y;
  assign out0_z_o      = out_tri_q.a.z;
  assign out1_x_o      = out_tri_q.b.x;
  assign out1_y_o      = out_tri_q.b.y;
  assign out1_z_o      = out_tri_q.b.z;
  assign out2_x_o      = out_tri_q.c.x;
  assign out2_y_o      = out_tri_q.c.y;
  assign out2_z_o      = out_tri_q.c.z;
  assign last_of_run_o = out_last_q;

  // A pending second triangle always sits behind a shown first one.
  `NPC_ASSERT(a_pend_shown, clk_i, rst_ni, pend_q |-> (out_valid_q && !out_last_q))
  `NPC_ASSERT(a_pend_drain, clk_i, rst_ni, $fell(pend_q) |-> $past(out_ready_i))
  `NPC_ASSERT(a_stall_holds, clk_i, rst_ni, (valid_q[Last] && !adv) |=> valid_q[Last])
  `NPC_NEVER(a_take_busy, clk_i, rst_ni, take && out_valid_q && !out_ready_i)

endmodule

// ===== bench/near_plane_triangle_clip_tb.sv =====
// Self-checking testbench for near_plane_triangle_clip: directed table then random triangles.
// Expected triangles come from a local clipping predictor; depends on npclip_pkg and the RTL.
`timescale 1ns / 100ps

module near_plane_triangle_clip_tb;

  localparam int CW = npclip_pkg::COORD_W;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam int LATENCY = 60;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [CW-1:0] coord_t;
  typedef struct {
    coord_t c[3];
  } vert_t;
  typedef struct {
    vert_t v[3];
  } tri_in_t;
  typedef struct {
    coord_t f[9];
    logic   last;
  } clip_tri_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [npclip_pkg::NEAR_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  coord_t vin [9];
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  coord_t vout [9];
  logic last_of_run_o;

  logic [npclip_pkg::NEAR_W-1:0] near_model;
  clip_tri_t expected_tris [$];
  tri_in_t dir [$];
  int mismatches = 0;
  int failed = 0;
  int idle_in_pct = 0;
  int stall_out_pct = 0;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < 9; i++) vin[i] = '0;
  end

  always #5 clk_i = ~clk_i;

  near_plane_triangle_clip i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o,
    .v0_x_i(vin[0]), .v0_y_i(vin[1]), .v0_z_i(vin[2]),
    .v1_x_i(vin[3]), .v1_y_i(vin[4]), .v1_z_i(vin[5]),
    .v2_x_i(vin[6]), .v2_y_i(vin[7]), .v2_z_i(vin[8]),
    .out_valid_o, .out_ready_i,
    .out0_x_o(vout[0]), .out0_y_o(vout[1]), .out0_z_o(vout[2]),
    .out1_x_o(vout[3]), .out1_y_o(vout[4]), .out1_z_o(vout[5]),
    .out2_x_o(vout[6]), .out2_y_o(vout[7]), .out2_z_o(vout[8]),
    .last_of_run_o
  );

  function automatic void queue_expected(clip_tri_t t);
    expected_tris.insert(expected_tris.size(), t);
  endfunction

  function automatic void add_row(tri_in_t t);
    dir.insert(dir.size(), t);
  endfunction

  function automatic coord_t cut_coord(coord_t p, coord_t q, logic [63:0] a, logic [63:0] b);
    logic signed [63:0] d;
    logic [127:0] mag;
    logic [127:0] off;
    logic signed [127:0] r;
    d = 64'(q) - 64'(p);
    mag = (d < 0) ? 128'(-d) : 128'(d);
    off = (mag * 128'(a) + 128'(b >> 1)) / 128'(b);
    r = (d < 0) ? 128'(p) - $signed(off) : 128'(p) + $signed(off);
    if (r > 128'(CMAX)) return CMAX;
    if (r < 128'(CMIN)) return CMIN;
    return coord_t'(r);
  endfunction

  function automatic vert_t cut_point(vert_t p, vert_t q);
    vert_t r;
    logic [63:0] a;
    logic [63:0] b;
    a = 64'(64'(p.c[2]) - $signed({1'b0, near_model}));
    b = 64'(64'(p.c[2]) - 64'(q.c[2]));
    for (int k = 0; k < 3; k++) r.c[k] = cut_coord(p.c[k], q.c[k], a, b);
    return r;
  endfunction

  function automatic clip_tri_t make_tri(vert_t a, vert_t b, vert_t c, logic last);
    clip_tri_t t;
    for (int k = 0; k < 3; k++) begin
      t.f[k] = a.c[k];
      t.f[3+k] = b.c[k];
      t.f[6+k] = c.c[k];
    end
    t.last = last;
    return t;
  endfunction

  function automatic void predict_clip(tri_in_t t);
    vert_t ins [3];
    vert_t outs [3];
    int ni;
    int no;
    ni = 0;
    no = 0;
    for (int i = 0; i < 3; i++) begin
      if ($signed(64'(t.v[i].c[2])) >= $signed({33'b0, near_model})) begin
        ins[ni] = t.v[i];
        ni++;
      end else begin
        outs[no] = t.v[i];
        no++;
      end
    end
    case (ni)
      3: queue_expected(make_tri(t.v[0], t.v[1], t.v[2], 1'b1));
      1: queue_expected(make_tri(ins[0], cut_point(ins[0], outs[0]),
                                 cut_point(ins[0], outs[1]), 1'b1));
      2: begin
        queue_expected(make_tri(ins[0], cut_point(ins[1], outs[0]),
                                cut_point(ins[0], outs[0]), 1'b0));
        queue_expected(make_tri(ins[0], ins[1], cut_point(ins[1], outs[0]), 1'b1));
      end
      default: ;
    endcase
  endfunction

  task automatic send_tri(tri_in_t t);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) vin[i] <= t.v[i/3].c[i%3];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_clip(t);
  endtask

  task automatic write_near(logic [npclip_pkg::NEAR_W-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_tris.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    near_model = value;
  endtask

  function automatic tri_in_t random_tri();
    tri_in_t t;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) begin
        if (mode == 0) t.v[i].c[k] = coord_t'($urandom());
        else t.v[i].c[k] = coord_t'($signed($urandom_range(200000)) - 100000);
        if (k == 2 && mode >= 2)
          t.v[i].c[k] = coord_t'($signed({1'b0, near_model}) + $signed($urandom_range(8000))
                                 - 4000);
      end
    return t;
  endfunction

  function automatic tri_in_t tri_of(coord_t z0, coord_t z1, coord_t z2, coord_t xy);
    tri_in_t t;
    t.v[0].c = '{xy, -xy, z0};
    t.v[1].c = '{-xy, xy, z1};
    t.v[2].c = '{xy ^ 32'h5a5a, 32'h0001_0000, z2};
    return t;
  endfunction

  // Output side: stalls, long hold-off, and comparison with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tris.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("Unexpected output transaction");
        end else begin
          clip_tri_t e;
          logic bad;
          e = expected_tris.pop_front();
          bad = (e.last !== last_of_run_o);
          for (int i = 0; i < 9; i++) if (e.f[i] !== vout[i]) bad = 1;
          if (bad) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %p last %0d, got %p last %0d",
                       e.f, e.last, vout, last_of_run_o);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= stall_out_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("near_plane_triangle_clip verification failed");
      $finish;
    end
  end

  initial begin
    int idle_set [4][2];
    near_model = npclip_pkg::NEAR_RESET;
    idle_set = '{'{0, 0}, '{80, 0}, '{0, 80}, '{14, 14}};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all in, none in, one in, two in, extreme coordinates.
    add_row(tri_of(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0000_8000));
    add_row(tri_of(-32'sh0001_0000, 32'sh0, 32'sh100, 32'h0000_8000));
    add_row(tri_of(32'h0001_0000, -32'sh0001_0000, -32'sh0002_0000, 32'h0001_0000));
    add_row(tri_of(-32'sh0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000));
    add_row(tri_of(32'sh1000, 32'h0001_0000, -32'sh0003_0000, 32'h0001_0000));
    add_row(tri_of(CMAX, CMIN, CMIN, CMAX));
    add_row(tri_of(CMAX, CMAX, CMIN, CMIN));
    add_row(tri_of(CMIN, CMAX, CMIN, CMAX));
    add_row(tri_of(32'sd6554, 32'sd6553, 32'sd6554, 32'hFFFF_FFFF));
    add_row(tri_of(CMAX, CMAX, CMAX, CMIN));
    add_row(tri_of(CMIN, CMIN, CMIN, CMAX));
    // All-in triangle with extreme coordinates: output is the input unchanged.
    begin
      tri_in_t t;
      t = tri_of(CMAX, CMAX, CMAX, CMIN);
      send_tri(t);
      in_valid_i <= 1'b0;
      while (expected_tris.size() != 0) @(posedge clk_i);
    end
    foreach (dir[i]) send_tri(dir[i]);

    write_near('0);
    for (int i = 0; i < 8; i++) send_tri(random_tri());
    write_near({npclip_pkg::NEAR_W{1'b1}});
    for (int i = 0; i < 8; i++) send_tri(random_tri());
    dir.delete();
    add_row(tri_of(CMAX, CMIN, 32'sh0, 32'h1234_5678));
    foreach (dir[i]) send_tri(dir[i]);

    for (int ph = 0; ph < 4; ph++) begin
      write_near(ph == 0 ? npclip_pkg::NEAR_W'(1)
                         : npclip_pkg::NEAR_W'($urandom_range(32'h0010_0000)));
      idle_in_pct = idle_set[ph][0];
      stall_out_pct = idle_set[ph][1];
      if (ph == 0) hold_off_cycles = 400;
      for (int i = 0; i < 200; i++) send_tri(random_tri());
    end
    idle_in_pct = 0;
    stall_out_pct = 0;
    write_near(npclip_pkg::NEAR_RESET);
    for (int i = 0; i < 10; i++) send_tri(random_tri());

    in_valid_i <= 1'b0;
    while (expected_tris.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (failed == 0) begin
      $display("near_plane_triangle_clip verification clean");
    end else begin
      $display("near_plane_triangle_clip verification failed");
    end
    $finish;
  end

endmodule
